FILE: rtl/core/msde_pkg.sv
// Shared types and encodings for the MIPS subset decode/execute block.
`default_nettype none

package msde_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned REG_IDX_W = 5;

  localparam logic [XLEN-1:0] SEQ_STEP = 32'd4;
  localparam logic [XLEN-1:0] JUMP_REGION_MASK = 32'hF000_0000;

  typedef enum logic [5:0] {
    OP_SPECIAL = 6'h00,
    OP_J       = 6'h02,
    OP_BEQ     = 6'h04,
    OP_BNE     = 6'h05,
    OP_ADDI    = 6'h08,
    OP_ADDIU   = 6'h09,
    OP_ANDI    = 6'h0C,
    OP_ORI     = 6'h0D,
    OP_XORI    = 6'h0E,
    OP_LUI     = 6'h0F,
    OP_LB      = 6'h20,
    OP_LH      = 6'h21,
    OP_LW      = 6'h23,
    OP_LBU     = 6'h24,
    OP_LHU     = 6'h25,
    OP_SB      = 6'h28,
    OP_SH      = 6'h29,
    OP_SW      = 6'h2B
  } opcode_e;

  typedef enum logic [5:0] {
    FN_SLL  = 6'h00,
    FN_SRL  = 6'h02,
    FN_JR   = 6'h08,
    FN_ADD  = 6'h20,
    FN_ADDU = 6'h21,
    FN_SUB  = 6'h22,
    FN_SUBU = 6'h23,
    FN_AND  = 6'h24,
    FN_OR   = 6'h25,
    FN_XOR  = 6'h26
  } funct_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_kind_e;

  typedef enum logic [2:0] {
    SZ_BYTE  = 3'd0,
    SZ_HALF  = 3'd1,
    SZ_WORD  = 3'd2,
    SZ_UBYTE = 3'd3,
    SZ_UHALF = 3'd4
  } access_size_e;

  typedef struct packed {
    logic [XLEN-1:0] instr_word;
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] rs_value;
    logic [XLEN-1:0] rt_value;
  } msde_in_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] dest_reg;
    logic                 dest_write;
    logic [XLEN-1:0]      dest_value;
    logic [XLEN-1:0]      next_pc;
    mem_kind_e            mem_kind;
    access_size_e         access_size;
    logic [XLEN-1:0]      mem_address;
    logic                 unknown_instr;
  } msde_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/mips_subset_decode_execute_top.sv
// Top level: MIPS32 integer subset decode and execute, one instruction per transaction.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (instr, pc, rs, rt)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (dest, next_pc, mem access)
//
// An input register feeds one pass of decode + ALU + PC logic into the result
// register. Throughput is one transaction per cycle while out is not stalled;
// the longest path is the pc+4 add chained into the branch target add.
// Reset clears only the two valid flags; payload registers are not reset.
// A stalled result holds in the result register while the input stage still takes
// a new transaction; input stalls only when both stages are full and out is stalled.
`default_nettype none

module mips_subset_decode_execute_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire msde_pkg::msde_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output msde_pkg::msde_out_t   out_data_o
);
  import msde_pkg::*;

  // ---------------------------------------------------------------------------
  // Handshake / pipeline control
  // ---------------------------------------------------------------------------
  logic      s1_valid_q, s1_valid_d;
  msde_in_t  s1_q;
  logic      out_valid_q, out_valid_d;
  msde_out_t out_q;
  msde_out_t exec_res;

  logic out_free;   // result register can take a new transaction this cycle
  logic s1_move;    // input stage hands its transaction to the result register
  logic in_take;    // input transaction accepted

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= exec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Decode and execute (single combinational pass on the input register)
  // ---------------------------------------------------------------------------
  logic [5:0]           op_raw;
  logic [5:0]           fn_raw;
  logic [REG_IDX_W-1:0] rt_idx;
  logic [REG_IDX_W-1:0] rd_idx;
  logic [4:0]           shamt;
  logic [XLEN-1:0]      zimm;
  logic [XLEN-1:0]      simm;
  logic [XLEN-1:0]      seq_pc;
  logic [XLEN-1:0]      br_target;
  logic [XLEN-1:0]      j_target;
  logic [XLEN-1:0]      ea;
  logic                 rs_eq_rt;

  assign op_raw    = s1_q.instr_word[31:26];
  assign rt_idx    = s1_q.instr_word[20:16];
  assign rd_idx    = s1_q.instr_word[15:11];
  assign shamt     = s1_q.instr_word[10:6];
  assign fn_raw    = s1_q.instr_word[5:0];
  assign zimm      = {16'h0000, s1_q.instr_word[15:0]};
  assign simm      = {{16{s1_q.instr_word[15]}}, s1_q.instr_word[15:0]};
  assign seq_pc    = s1_q.pc + SEQ_STEP;
  assign br_target = seq_pc + {simm[XLEN-3:0], 2'b00};
  assign j_target  = (seq_pc & JUMP_REGION_MASK) | {4'h0, s1_q.instr_word[25:0], 2'b00};
  assign ea        = s1_q.rs_value + simm;
  assign rs_eq_rt  = (s1_q.rs_value == s1_q.rt_value);

  always_comb begin
    exec_res               = '0;
    exec_res.next_pc       = seq_pc;
    exec_res.mem_kind      = MEM_NONE;
    exec_res.access_size   = SZ_BYTE;
    unique case (opcode_e'(op_raw))
      OP_SPECIAL: begin
        exec_res.dest_reg   = rd_idx;
        exec_res.dest_write = 1'b1;
        unique case (funct_e'(fn_raw))
          FN_ADD, FN_ADDU: exec_res.dest_value = s1_q.rs_value + s1_q.rt_value;
          FN_SUB, FN_SUBU: exec_res.dest_value = s1_q.rs_value - s1_q.rt_value;
          FN_AND:          exec_res.dest_value = s1_q.rs_value & s1_q.rt_value;
          FN_OR:           exec_res.dest_value = s1_q.rs_value | s1_q.rt_value;
          FN_XOR:          exec_res.dest_value = s1_q.rs_value ^ s1_q.rt_value;
          FN_SLL:          exec_res.dest_value = s1_q.rt_value << shamt;
          FN_SRL:          exec_res.dest_value = s1_q.rt_value >> shamt;
          FN_JR: begin
            exec_res.dest_reg   = '0;
            exec_res.dest_write = 1'b0;
            exec_res.next_pc    = s1_q.rs_value;
          end
          default: begin
            exec_res.dest_reg      = '0;
            exec_res.dest_write    = 1'b0;
            exec_res.unknown_instr = 1'b1;
          end
        endcase
      end
      OP_ADDI, OP_ADDIU: begin
        exec_res.dest_reg   = rt_idx;
        exec_res.dest_write = 1'b1;
        exec_res.dest_value = ea;
      end
      OP_ANDI: begin
        exec_res.dest_reg   = rt_idx;
        exec_res.dest_write = 1'b1;
        exec_res.dest_value = s1_q.rs_value & zimm;
      end
      OP_ORI: begin
        exec_res.dest_reg   = rt_idx;
        exec_res.dest_write = 1'b1;
        exec_res.dest_value = s1_q.rs_value | zimm;
      end
      OP_XORI: begin
        exec_res.dest_reg   = rt_idx;
        exec_res.dest_write = 1'b1;
        exec_res.dest_value = s1_q.rs_value ^ zimm;
      end
      OP_LUI: begin
        exec_res.dest_reg   = rt_idx;
        exec_res.dest_write = 1'b1;
        exec_res.dest_value = {s1_q.instr_word[15:0], 16'h0000};
      end
      OP_BEQ: begin
        if (rs_eq_rt) begin
          exec_res.next_pc = br_target;
        end
      end
      OP_BNE: begin
        if (!rs_eq_rt) begin
          exec_res.next_pc = br_target;
        end
      end
      OP_J: exec_res.next_pc = j_target;
      // loads report rt as destination but write it later
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        exec_res.dest_reg    = rt_idx;
        exec_res.mem_kind    = MEM_LOAD;
        exec_res.mem_address = ea;
        unique case (opcode_e'(op_raw))
          OP_LB:   exec_res.access_size = SZ_BYTE;
          OP_LH:   exec_res.access_size = SZ_HALF;
          OP_LW:   exec_res.access_size = SZ_WORD;
          OP_LBU:  exec_res.access_size = SZ_UBYTE;
          default: exec_res.access_size = SZ_UHALF;
        endcase
      end
      OP_SB, OP_SH, OP_SW: begin
        exec_res.mem_kind    = MEM_STORE;
        exec_res.mem_address = ea;
        unique case (opcode_e'(op_raw))
          OP_SB:   exec_res.access_size = SZ_BYTE;
          OP_SH:   exec_res.access_size = SZ_HALF;
          default: exec_res.access_size = SZ_WORD;
        endcase
      end
      default: exec_res.unknown_instr = 1'b1;
    endcase
  end

`ifndef NO_ASSERTIONS
  // accepted transaction lands in the input register
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q && (s1_q == $past(in_data_i)))
    else $error("input register did not capture accepted transaction");

  // handoff delivers the decode of the input register to the result register
  a_out_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_o && (out_data_o == $past(exec_res)))
    else $error("result register does not match decoded transaction");

  // input backpressure only when both stages hold work and output is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without downstream backpressure");

  // unknown encodings produce no write and no memory access
  a_unknown_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unknown_instr |->
      !out_data_o.dest_write && (out_data_o.mem_kind == MEM_NONE))
    else $error("unknown instruction produced side effects");

  // memory accesses never write the destination immediately
  a_mem_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.mem_kind != MEM_NONE) |-> !out_data_o.dest_write)
    else $error("memory access with immediate register write");
`endif

endmodule

`default_nettype wire
